FILE: hw/rtl/lpht_pkg.sv
`default_nettype none
package lpht_pkg;
    localparam int SLOTS = 1024;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int LIMIT_X10 = SLOTS * 7;
    localparam int LOAD_W = $clog2(SLOTS * 10 + 1);

    localparam logic [1:0] ACT_PUT = 2'd0;
    localparam logic [1:0] ACT_GET = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] lookup_key;
        logic [31:0] data_in;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] data_out;
    } rsp_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [63:0]      lookup_key;
        logic [31:0]      data_in;
        logic [IDX_W-1:0] home;
    } job_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_PROBE,
        S_WRITE,
        S_OUT
    } bstate_t;
endpackage
`default_nettype wire

FILE: hw/rtl/linear_probe_hash_table_core.sv
`default_nettype none
// Key-to-value map of 1024 slots with linear probing. A three-stage hash
// pipeline feeds a two-entry queue; the probe engine reads one slot per
// cycle from a memory with one read port and one write port, and walks
// up to 1024 slots for an item. After reset the engine clears all slot
// marks, one slot per cycle, before it takes the first item.
module linear_probe_hash_table_core (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             in_valid,
    output logic            in_ready,
    input  lpht_pkg::req_t  in_item,
    output logic            out_valid,
    input  wire             out_ready,
    output lpht_pkg::rsp_t  out_item
);
    logic fq_valid, fq_ready, qb_valid, qb_ready;
    lpht_pkg::job_t fq_job, qb_job;

    lpht_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
    );

    lpht_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_job(fq_job),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_job(qb_job)
    );

    lpht_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
    );
endmodule
`default_nettype wire

FILE: hw/rtl/lpht_front.sv
`default_nettype none
module lpht_front (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_ready,
    input  lpht_pkg::req_t   in_item,
    output logic             job_valid,
    input  wire              job_ready,
    output lpht_pkg::job_t   job
);
    // Three-stage hash pipeline; each stage holds one item.
    logic [2:0] v_reg, v_next;
    lpht_pkg::req_t r0_reg, r1_reg, r2_reg;
    logic [63:0] k0_reg, k1_reg, k2_reg;
    logic [63:0] a0, a1, a2, b1, b2, c2;
    logic adv2, adv1, adv0;

    assign adv2 = !v_reg[2] || job_ready;
    assign adv1 = !v_reg[1] || adv2;
    assign adv0 = !v_reg[0] || adv1;
    assign in_ready = adv0;

    always_comb
    begin
        a0 = (~in_item.lookup_key) + (in_item.lookup_key << 21);
        a0 = a0 ^ (a0 >> 24);
        a1 = (k0_reg + (k0_reg << 3)) + (k0_reg << 8);
        b1 = a1 ^ (a1 >> 14);
        a2 = (k1_reg + (k1_reg << 2)) + (k1_reg << 4);
        b2 = a2 ^ (a2 >> 28);
        c2 = b2 + (b2 << 31);
    end

    always_comb
    begin
        v_next = v_reg;
        if (adv2)
        begin
            v_next[2] = v_reg[1];
        end
        if (adv1)
        begin
            v_next[1] = v_reg[0];
        end
        if (adv0)
        begin
            v_next[0] = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv0)
        begin
            r0_reg <= in_item;
            k0_reg <= a0;
        end
        if (adv1)
        begin
            r1_reg <= r0_reg;
            k1_reg <= b1;
        end
        if (adv2)
        begin
            r2_reg <= r1_reg;
            k2_reg <= c2;
        end
    end

    assign job_valid = v_reg[2];
    assign job.action = r2_reg.action;
    assign job.lookup_key = r2_reg.lookup_key;
    assign job.data_in = r2_reg.data_in;
    assign job.home = k2_reg[lpht_pkg::IDX_W-1:0];
endmodule
`default_nettype wire

FILE: hw/rtl/lpht_queue.sv
`default_nettype none
module lpht_queue (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             wr_valid,
    output logic            wr_ready,
    input  lpht_pkg::job_t  wr_job,
    output logic            rd_valid,
    input  wire             rd_ready,
    output lpht_pkg::job_t  rd_job
);
    lpht_pkg::job_t q_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic do_wr, do_rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_job = q_reg[rp_reg];
    assign do_wr = wr_valid && wr_ready;
    assign do_rd = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= !wp_reg;
            end
            if (do_rd)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_reg[wp_reg] <= wr_job;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/lpht_back.sv
`default_nettype none
module lpht_back (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              job_valid,
    output logic             job_ready,
    input  lpht_pkg::job_t   job,
    output logic             out_valid,
    input  wire              out_ready,
    output lpht_pkg::rsp_t   out_item
);
    localparam int IW = lpht_pkg::IDX_W;
    localparam int CW = lpht_pkg::CNT_W;
    localparam int LW = lpht_pkg::LOAD_W;

    // Slot memory: key, value and used/dead marks share one address.
    logic [97:0] mem [lpht_pkg::SLOTS];
    logic [97:0] rd_reg;
    logic [IW-1:0] raddr;
    logic          re;
    logic          we;
    logic [IW-1:0] waddr;
    logic [97:0]   wdata;

    lpht_pkg::bstate_t st_reg, st_next;
    lpht_pkg::job_t j_reg;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW:0]   n_reg, n_next;
    logic [IW-1:0] free_reg, free_next;
    logic          has_free_reg, has_free_next;
    logic          hit_reg, hit_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [CW-1:0] live_reg, live_next;
    lpht_pkg::rsp_t rsp_reg, rsp_next;
    logic [IW-1:0] nxt_idx;
    logic          s_used, s_dead, s_match, full_load;
    logic [LW-1:0] load_x10;

    assign s_used = rd_reg[97];
    assign s_dead = rd_reg[96];
    assign s_match = s_used && !s_dead && rd_reg[95:32] == j_reg.lookup_key;
    assign nxt_idx = (idx_reg == IW'(lpht_pkg::SLOTS - 1)) ? '0 : idx_reg + 1'b1;
    assign load_x10 = LW'(live_reg) * LW'(10);
    assign full_load = load_x10 >= LW'(lpht_pkg::LIMIT_X10);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_reg <= mem[raddr];
        end
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            lpht_pkg::S_CLEAR:
            begin
                if (idx_reg == IW'(lpht_pkg::SLOTS - 1))
                begin
                    st_next = lpht_pkg::S_IDLE;
                end
            end
            lpht_pkg::S_IDLE:
            begin
                if (job_valid)
                begin
                    st_next = lpht_pkg::S_READ;
                end
            end
            lpht_pkg::S_READ:
            begin
                st_next = lpht_pkg::S_PROBE;
            end
            lpht_pkg::S_PROBE:
            begin
                if (s_match || !s_used || n_reg == (IW + 1)'(lpht_pkg::SLOTS - 1))
                begin
                    st_next = lpht_pkg::S_WRITE;
                end
            end
            lpht_pkg::S_WRITE:
            begin
                st_next = lpht_pkg::S_OUT;
            end
            lpht_pkg::S_OUT:
            begin
                if (out_ready)
                begin
                    st_next = lpht_pkg::S_IDLE;
                end
            end
            default:
            begin
                st_next = lpht_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        job_ready = 1'b0;
        re = 1'b0;
        raddr = idx_reg;
        we = 1'b0;
        waddr = idx_reg;
        wdata = '0;
        idx_next = idx_reg;
        n_next = n_reg;
        free_next = free_reg;
        has_free_next = has_free_reg;
        hit_next = hit_reg;
        hit_idx_next = hit_idx_reg;
        live_next = live_reg;
        rsp_next = rsp_reg;
        case (st_reg)
            lpht_pkg::S_CLEAR:
            begin
                we = 1'b1;
                idx_next = nxt_idx;
            end
            lpht_pkg::S_IDLE:
            begin
                job_ready = 1'b1;
                re = job_valid;
                raddr = job.home;
                idx_next = job.home;
                n_next = '0;
                has_free_next = 1'b0;
                hit_next = 1'b0;
            end
            lpht_pkg::S_READ:
            begin
            end
            lpht_pkg::S_PROBE:
            begin
                if ((!s_used || s_dead) && !has_free_reg)
                begin
                    has_free_next = 1'b1;
                    free_next = idx_reg;
                end
                if (s_match)
                begin
                    hit_next = 1'b1;
                    hit_idx_next = idx_reg;
                end
                else if (s_used && n_reg != (IW + 1)'(lpht_pkg::SLOTS - 1))
                begin
                    re = 1'b1;
                    raddr = nxt_idx;
                    idx_next = nxt_idx;
                    n_next = n_reg + 1'b1;
                end
            end
            lpht_pkg::S_WRITE:
            begin
                rsp_next.status = lpht_pkg::ST_MISSING;
                rsp_next.data_out = '0;
                case (j_reg.action)
                    lpht_pkg::ACT_PUT:
                    begin
                        if (hit_reg)
                        begin
                            we = 1'b1;
                            waddr = hit_idx_reg;
                            wdata = {2'b10, j_reg.lookup_key, j_reg.data_in};
                            rsp_next.status = lpht_pkg::ST_DONE;
                        end
                        else if (full_load || !has_free_reg)
                        begin
                            rsp_next.status = lpht_pkg::ST_FULL;
                        end
                        else
                        begin
                            we = 1'b1;
                            waddr = free_reg;
                            wdata = {2'b10, j_reg.lookup_key, j_reg.data_in};
                            live_next = live_reg + 1'b1;
                            rsp_next.status = lpht_pkg::ST_DONE;
                        end
                    end
                    lpht_pkg::ACT_GET:
                    begin
                        if (hit_reg)
                        begin
                            rsp_next.status = lpht_pkg::ST_DONE;
                            rsp_next.data_out = rd_reg[31:0];
                        end
                    end
                    lpht_pkg::ACT_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            we = 1'b1;
                            waddr = hit_idx_reg;
                            wdata = {2'b11, rd_reg[95:0]};
                            if (live_reg != '0)
                            begin
                                live_next = live_reg - 1'b1;
                            end
                            rsp_next.status = lpht_pkg::ST_DONE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            lpht_pkg::S_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= lpht_pkg::S_CLEAR;
            idx_reg <= '0;
            n_reg <= '0;
            has_free_reg <= 1'b0;
            hit_reg <= 1'b0;
            live_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            idx_reg <= idx_next;
            n_reg <= n_next;
            has_free_reg <= has_free_next;
            hit_reg <= hit_next;
            live_reg <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_reg <= free_next;
        hit_idx_reg <= hit_idx_next;
        rsp_reg <= rsp_next;
        if (st_reg == lpht_pkg::S_IDLE && job_valid)
        begin
            j_reg <= job;
        end
    end

    assign out_valid = st_reg == lpht_pkg::S_OUT;
    assign out_item = rsp_reg;

`ifndef ASSERT_OFF
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CW'(lpht_pkg::SLOTS))
        else $error("live count above capacity");
    a_no_job_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == lpht_pkg::S_CLEAR |-> !job_ready)
        else $error("job taken during clear");
    a_live_step: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg != lpht_pkg::S_WRITE |=> live_reg == $past(live_reg))
        else $error("live count moved outside write");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result dropped");
`endif
endmodule
`default_nettype wire
